>>> rtl/fbr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the best-fit range allocator.
// No dependencies; imported by the cells and the top level.
package fbr_pkg;

    // Index width in scan packets: enough for 2048 free slots
    localparam int IDX_W = 11;

    localparam int DEF_SPACE_BITS = 32;
    localparam int DEF_MAX_ALLOCS = 64;
    localparam int DEF_TAG_BITS   = 16;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_CLEANUP = 2'd2,
        OP_LOOKUP  = 2'd3
    } op_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_FIT   = 3'd1;
    localparam logic [2:0] ST_NOT_LIVE = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INJ,
        S_WAIT,
        S_REL_RD,
        S_RESP
    } fsm_t;

    // Scan packet walking the free-block chain
    typedef struct packed {
        logic             vld;
        logic [32:0]      size;
        logic [31:0]      key;
        logic             fit_found;
        logic [IDX_W-1:0] fit_idx;
        logic [32:0]      fit_len;
        logic [31:0]      fit_age;
        logic [31:0]      fit_base;
        logic             hole_found;
        logic [IDX_W-1:0] hole_idx;
        logic             prv_found;
        logic [IDX_W-1:0] prv_idx;
        logic [31:0]      prv_base;
        logic [32:0]      prv_len;
        logic             nxt_found;
        logic [IDX_W-1:0] nxt_idx;
        logic [31:0]      nxt_base;
        logic [32:0]      nxt_len;
    } fpkt_t;

    // Update broadcast to the free-block chain
    typedef struct packed {
        logic             kill_a_en;
        logic [IDX_W-1:0] kill_a_idx;
        logic             kill_b_en;
        logic [IDX_W-1:0] kill_b_idx;
        logic             ins_en;
        logic [IDX_W-1:0] ins_idx;
        logic [31:0]      ins_base;
        logic [32:0]      ins_len;
        logic [31:0]      ins_age;
    } fwr_t;

    // Scan packet walking the live-allocation chain
    typedef struct packed {
        logic             vld;
        logic [31:0]      addr;
        logic             hit_found;
        logic [IDX_W-1:0] hit_idx;
        logic [31:0]      hit_base;
        logic [32:0]      hit_len;
        logic [15:0]      hit_tag;
        logic             hole_found;
        logic [IDX_W-1:0] hole_idx;
        logic [IDX_W-1:0] used;
    } lpkt_t;

    // Update broadcast to the live-allocation chain
    typedef struct packed {
        logic             kill_en;
        logic [IDX_W-1:0] kill_idx;
        logic             ins_en;
        logic [IDX_W-1:0] ins_idx;
        logic [31:0]      ins_base;
        logic [32:0]      ins_len;
        logic [15:0]      ins_tag;
    } lwr_t;

endpackage

>>> rtl/best_fit_range_allocator.sv
`timescale 1ns / 1ps
// Best-fit range allocator: an address space of 2^SPACE_BITS units handed out
// on request. Input transfers on s_*: tuser carries the action (allocate, free,
// cleanup, lookup), tdata the size, address and resource tag. Every input
// transfer yields exactly one result transfer on m_* (status, base, tag,
// free units left).
// Free blocks sit in a row of MAX_ALLOCS+1 cells, live allocations in a row of
// MAX_ALLOCS cells; a scan packet moves one cell per cycle down both rows.
// Allocate, free and lookup each make one scan down the free-block row, and
// the decision is taken once the packet leaves its tail. Cleanup makes one
// full row scan per queued stale allocation.
// One item is in work at a time; s_tready is high only while idle, so a new
// transfer is taken only after the last one's result is in the output register.
// The result sits in an output register; a stalled receiver holds it, and the
// next item is accepted and worked on but its result waits for the register.
// Reset (aresetn low, synchronous): one free block covering the whole space,
// no live allocations, empty stale queue. No clearing pass is needed.
// Depends on fbr_pkg, fbr_free_cell and fbr_live_cell.
module best_fit_range_allocator #(
    parameter int SPACE_BITS = fbr_pkg::DEF_SPACE_BITS,
    parameter int MAX_ALLOCS = fbr_pkg::DEF_MAX_ALLOCS,
    parameter int TAG_BITS   = fbr_pkg::DEF_TAG_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // alloc_size[32:0], address[64:33], resource_id[80:65]
    input  logic [1:0]  s_tuser,  // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata   // status[2:0], base_offset[34:3],
                                  // found_resource[50:35], free_space[83:51]
);
    import fbr_pkg::*;

    localparam int FSLOTS = MAX_ALLOCS + 1;
    localparam int SIDX_W = $clog2(MAX_ALLOCS);
    localparam int SCNT_W = $clog2(MAX_ALLOCS + 1);
    localparam int TAG_W  = (TAG_BITS < 16) ? TAG_BITS : 16;
    localparam logic [32:0] SPACE = 33'd1 << SPACE_BITS;

    fsm_t state_reg, state_next;

    // Item registers
    op_t         op_reg;
    logic [32:0] size_reg;
    logic [31:0] addr_reg;
    logic [15:0] tag_reg;

    logic [SCNT_W-1:0] stale_count_reg;
    logic [SIDX_W-1:0] rel_idx_reg;
    logic [32:0]       free_units_reg;
    logic [31:0]       ins_ctr_reg;
    lpkt_t             lres_reg;

    logic [2:0]  res_status_reg;
    logic [31:0] res_base_reg;
    logic [15:0] res_tag_reg;

    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg;

    // Stale queue memory
    logic [31:0] stale_base_mem [MAX_ALLOCS];
    logic [32:0] stale_len_mem  [MAX_ALLOCS];
    logic [31:0] stale_rd_base_reg;
    logic [32:0] stale_rd_len_reg;

    // Cell rows
    fpkt_t fpkt [FSLOTS+1];
    lpkt_t lpkt [MAX_ALLOCS+1];
    fwr_t  fwr;
    lwr_t  lwr;
    fpkt_t ft;

    logic s_acc;
    logic decide;
    logic last_rel;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign ft       = fpkt[FSLOTS];
    assign decide   = (state_reg == S_WAIT) && ft.vld;
    assign last_rel = (SCNT_W'(rel_idx_reg) + 1'b1) == stale_count_reg;

    // Packet injection at the head of both rows
    always_comb begin
        fpkt[0]      = '0;
        fpkt[0].vld  = (state_reg == S_INJ);
        fpkt[0].size = size_reg;
        fpkt[0].key  = (op_reg == OP_CLEANUP) ? stale_rd_base_reg : addr_reg;
        lpkt[0]      = '0;
        lpkt[0].vld  = (state_reg == S_INJ);
        lpkt[0].addr = addr_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < FSLOTS; gi++) begin : g_free
            fbr_free_cell #(.INDEX(gi), .SPACE_BITS(SPACE_BITS)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .pkt_in  (fpkt[gi]),
                .pkt_out (fpkt[gi+1]),
                .wr      (fwr)
            );
        end
        for (gi = 0; gi < MAX_ALLOCS; gi++) begin : g_live
            fbr_live_cell #(.INDEX(gi), .TAG_BITS(TAG_BITS)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .pkt_in  (lpkt[gi]),
                .pkt_out (lpkt[gi+1]),
                .wr      (lwr)
            );
        end
    endgenerate

    // Decision once the free-row packet reaches the tail
    logic [IDX_W:0]    used;
    logic [32:0]       rem;
    logic [33:0]       prv_end;
    logic              merge_p, merge_n;
    logic [31:0]       nb;
    logic [33:0]       nl;
    logic [34:0]       nl2;
    logic [34:0]       nb_end;
    logic              slot_ok;
    logic [IDX_W-1:0]  slot_idx;
    logic [2:0]        d_status;
    logic [31:0]       d_base;
    logic [15:0]       d_tag;
    logic [32:0]       fu_next;
    logic              ctr_inc;
    logic              stale_push;

    always_comb begin
        used     = {1'b0, lres_reg.used} + (IDX_W+1)'(stale_count_reg);
        rem      = ft.fit_len - size_reg;
        prv_end  = {2'b0, ft.prv_base} + {1'b0, ft.prv_len};
        merge_p  = ft.prv_found && (prv_end == {2'b0, stale_rd_base_reg});
        nb       = merge_p ? ft.prv_base : stale_rd_base_reg;
        nl       = {1'b0, stale_rd_len_reg} + (merge_p ? {1'b0, ft.prv_len} : 34'd0);
        nb_end   = {3'b0, nb} + {1'b0, nl};
        merge_n  = ft.nxt_found && (nb_end == {3'b0, ft.nxt_base});
        nl2      = {1'b0, nl} + (merge_n ? {2'b0, ft.nxt_len} : 35'd0);

        // Lowest free slot once merged neighbors are gone
        slot_ok  = ft.hole_found;
        slot_idx = ft.hole_idx;
        if (merge_p && (!slot_ok || ft.prv_idx < slot_idx)) begin
            slot_ok  = 1'b1;
            slot_idx = ft.prv_idx;
        end
        if (merge_n && (!slot_ok || ft.nxt_idx < slot_idx)) begin
            slot_ok  = 1'b1;
            slot_idx = ft.nxt_idx;
        end

        fwr        = '0;
        lwr        = '0;
        d_status   = ST_OK;
        d_base     = '0;
        d_tag      = '0;
        fu_next    = free_units_reg;
        ctr_inc    = 1'b0;
        stale_push = 1'b0;

        case (op_reg)
            OP_ALLOC: begin
                if (size_reg == 33'd0) begin
                    d_status = ST_BAD_SIZE;
                end else if (used >= (IDX_W+1)'(MAX_ALLOCS)) begin
                    d_status = ST_FULL;
                end else if (!ft.fit_found) begin
                    d_status = ST_NO_FIT;
                end else begin
                    d_base         = ft.fit_base;
                    fwr.kill_a_en  = 1'b1;
                    fwr.kill_a_idx = ft.fit_idx;
                    if (rem != 33'd0) begin
                        fwr.ins_en   = 1'b1;
                        fwr.ins_idx  = (ft.hole_found && ft.hole_idx < ft.fit_idx) ?
                                       ft.hole_idx : ft.fit_idx;
                        fwr.ins_base = ft.fit_base + size_reg[31:0];
                        fwr.ins_len  = rem;
                        fwr.ins_age  = ins_ctr_reg;
                        ctr_inc      = 1'b1;
                    end
                    fu_next      = free_units_reg - size_reg;
                    lwr.ins_en   = 1'b1;
                    lwr.ins_idx  = lres_reg.hole_idx;
                    lwr.ins_base = ft.fit_base;
                    lwr.ins_len  = size_reg;
                    lwr.ins_tag  = tag_reg;
                end
            end
            OP_FREE, OP_LOOKUP: begin
                if (!lres_reg.hit_found) begin
                    d_status = ST_NOT_LIVE;
                end else begin
                    d_base = lres_reg.hit_base;
                    d_tag  = lres_reg.hit_tag;
                    if (op_reg == OP_FREE) begin
                        lwr.kill_en  = 1'b1;
                        lwr.kill_idx = lres_reg.hit_idx;
                        stale_push   = (stale_count_reg < SCNT_W'(MAX_ALLOCS));
                    end
                end
            end
            OP_CLEANUP: begin
                fu_next        = free_units_reg + stale_rd_len_reg;
                fwr.kill_a_en  = merge_p;
                fwr.kill_a_idx = ft.prv_idx;
                fwr.kill_b_en  = merge_n;
                fwr.kill_b_idx = ft.nxt_idx;
                fwr.ins_en     = slot_ok;
                fwr.ins_idx    = slot_idx;
                fwr.ins_base   = nb;
                fwr.ins_len    = nl2[32:0];
                fwr.ins_age    = ins_ctr_reg;
                ctr_inc        = slot_ok;
            end
            default: begin
                d_status = ST_OK;
            end
        endcase

        if (!decide) begin
            fwr        = '0;
            lwr        = '0;
            ctr_inc    = 1'b0;
            stale_push = 1'b0;
            fu_next    = free_units_reg;
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (op_t'(s_tuser) != OP_CLEANUP) begin
                        state_next = S_INJ;
                    end else if (stale_count_reg == '0) begin
                        state_next = S_RESP;
                    end else begin
                        state_next = S_REL_RD;
                    end
                end
            end
            S_REL_RD: state_next = S_INJ;
            S_INJ:    state_next = S_WAIT;
            S_WAIT: begin
                if (ft.vld) begin
                    if (op_reg == OP_CLEANUP && !last_rel) begin
                        state_next = S_REL_RD;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_count_reg <= '0;
            rel_idx_reg     <= '0;
            free_units_reg  <= SPACE;
            ins_ctr_reg     <= 32'd1;
            m_tvalid_reg    <= 1'b0;
        end else begin
            free_units_reg <= fu_next;
            if (ctr_inc) begin
                ins_ctr_reg <= ins_ctr_reg + 32'd1;
            end
            if (s_acc) begin
                rel_idx_reg <= '0;
            end
            if (stale_push) begin
                stale_count_reg <= stale_count_reg + 1'b1;
            end
            if (decide && op_reg == OP_CLEANUP) begin
                if (last_rel) begin
                    stale_count_reg <= '0;
                end else begin
                    rel_idx_reg <= rel_idx_reg + 1'b1;
                end
            end
            if (state_reg == S_RESP && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg         <= op_t'(s_tuser);
            size_reg       <= s_tdata[32:0];
            addr_reg       <= s_tdata[64:33];
            tag_reg        <= 16'(s_tdata[65 +: TAG_W]);
            res_status_reg <= ST_OK;
            res_base_reg   <= '0;
            res_tag_reg    <= '0;
        end
        if (lpkt[MAX_ALLOCS].vld) begin
            lres_reg <= lpkt[MAX_ALLOCS];
        end
        if (decide && op_reg != OP_CLEANUP) begin
            res_status_reg <= d_status;
            res_base_reg   <= d_base;
            res_tag_reg    <= d_tag;
        end
        if (state_reg == S_RESP && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {4'd0, free_units_reg, res_tag_reg, res_base_reg,
                            res_status_reg};
        end
    end

    // Stale queue: push on free, read one entry per release
    always_ff @(posedge aclk) begin
        if (stale_push) begin
            stale_base_mem[stale_count_reg[SIDX_W-1:0]] <= lres_reg.hit_base;
            stale_len_mem[stale_count_reg[SIDX_W-1:0]]  <= lres_reg.hit_len;
        end
        if (state_reg == S_REL_RD) begin
            stale_rd_base_reg <= stale_base_mem[rel_idx_reg];
            stale_rd_len_reg  <= stale_len_mem[rel_idx_reg];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_stale_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stale_count_reg <= SCNT_W'(MAX_ALLOCS))
        else $error("stale queue overflow");
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_units_reg <= SPACE)
        else $error("free units exceed space");
    a_tail_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        ft.vld |-> state_reg == S_WAIT)
        else $error("scan packet outside wait state");
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WAIT) |=> !$past(s_acc))
        else $error("item accepted during scan");
`endif

endmodule

>>> rtl/fbr_free_cell.sv
`timescale 1ns / 1ps
// One free-block slot: holds a block and folds it into the passing scan packet.
// Depends on fbr_pkg.
module fbr_free_cell #(
    parameter int INDEX      = 0,
    parameter int SPACE_BITS = fbr_pkg::DEF_SPACE_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  fbr_pkg::fpkt_t pkt_in,
    output fbr_pkg::fpkt_t pkt_out,
    input  fbr_pkg::fwr_t  wr
);
    import fbr_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [32:0] SPACE = 33'd1 << SPACE_BITS;

    logic        valid_reg;
    logic [31:0] base_reg;
    logic [32:0] len_reg;
    logic [31:0] age_reg;
    fpkt_t       pkt_reg;
    fpkt_t       pkt_next;

    // Fold this slot into the packet
    always_comb begin
        pkt_next = pkt_in;
        if (valid_reg) begin
            if (len_reg >= pkt_in.size &&
                (!pkt_in.fit_found || len_reg < pkt_in.fit_len ||
                 (len_reg == pkt_in.fit_len && age_reg < pkt_in.fit_age))) begin
                pkt_next.fit_found = 1'b1;
                pkt_next.fit_idx   = MY_IDX;
                pkt_next.fit_len   = len_reg;
                pkt_next.fit_age   = age_reg;
                pkt_next.fit_base  = base_reg;
            end
            if (base_reg <= pkt_in.key) begin
                if (!pkt_in.prv_found || base_reg > pkt_in.prv_base) begin
                    pkt_next.prv_found = 1'b1;
                    pkt_next.prv_idx   = MY_IDX;
                    pkt_next.prv_base  = base_reg;
                    pkt_next.prv_len   = len_reg;
                end
            end else begin
                if (!pkt_in.nxt_found || base_reg < pkt_in.nxt_base) begin
                    pkt_next.nxt_found = 1'b1;
                    pkt_next.nxt_idx   = MY_IDX;
                    pkt_next.nxt_base  = base_reg;
                    pkt_next.nxt_len   = len_reg;
                end
            end
        end else if (!pkt_in.hole_found) begin
            pkt_next.hole_found = 1'b1;
            pkt_next.hole_idx   = MY_IDX;
        end
    end

    // Packet register toward the neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_reg.vld <= 1'b0;
        end else begin
            pkt_reg <= pkt_next;
        end
    end
    assign pkt_out = pkt_reg;

    // Slot contents: removal first, then insertion wins
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= (INDEX == 0);
            base_reg  <= '0;
            len_reg   <= SPACE;
            age_reg   <= '0;
        end else begin
            if ((wr.kill_a_en && wr.kill_a_idx == MY_IDX) ||
                (wr.kill_b_en && wr.kill_b_idx == MY_IDX)) begin
                valid_reg <= 1'b0;
            end
            if (wr.ins_en && wr.ins_idx == MY_IDX) begin
                valid_reg <= 1'b1;
                base_reg  <= wr.ins_base;
                len_reg   <= wr.ins_len;
                age_reg   <= wr.ins_age;
            end
        end
    end

endmodule

>>> rtl/fbr_live_cell.sv
`timescale 1ns / 1ps
// One live-allocation slot: holds a region and folds it into the scan packet.
// Depends on fbr_pkg.
module fbr_live_cell #(
    parameter int INDEX    = 0,
    parameter int TAG_BITS = fbr_pkg::DEF_TAG_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  fbr_pkg::lpkt_t pkt_in,
    output fbr_pkg::lpkt_t pkt_out,
    input  fbr_pkg::lwr_t  wr
);
    import fbr_pkg::*;

    localparam int TAG_W = (TAG_BITS < 16) ? TAG_BITS : 16;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic             valid_reg;
    logic [31:0]      base_reg;
    logic [32:0]      len_reg;
    logic [TAG_W-1:0] tag_reg;
    lpkt_t            pkt_reg;
    lpkt_t            pkt_next;
    logic [31:0]      offs;

    assign offs = pkt_in.addr - base_reg;

    // Fold this slot into the packet
    always_comb begin
        pkt_next = pkt_in;
        if (valid_reg) begin
            pkt_next.used = pkt_in.used + 1'b1;
            if (!pkt_in.hit_found && base_reg <= pkt_in.addr &&
                {1'b0, offs} < len_reg) begin
                pkt_next.hit_found = 1'b1;
                pkt_next.hit_idx   = MY_IDX;
                pkt_next.hit_base  = base_reg;
                pkt_next.hit_len   = len_reg;
                pkt_next.hit_tag   = 16'(tag_reg);
            end
        end else if (!pkt_in.hole_found) begin
            pkt_next.hole_found = 1'b1;
            pkt_next.hole_idx   = MY_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_reg.vld <= 1'b0;
        end else begin
            pkt_reg <= pkt_next;
        end
    end
    assign pkt_out = pkt_reg;

    // Valid bit under reset, payload only written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            if (wr.kill_en && wr.kill_idx == MY_IDX) begin
                valid_reg <= 1'b0;
            end
            if (wr.ins_en && wr.ins_idx == MY_IDX) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.ins_en && wr.ins_idx == MY_IDX) begin
            base_reg <= wr.ins_base;
            len_reg  <= wr.ins_len;
            tag_reg  <= wr.ins_tag[TAG_W-1:0];
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for best_fit_range_allocator: directed and random
// allocate/free/cleanup/lookup transfers, checked against an in-bench predictor.
// Depends on fbr_pkg and the allocator RTL.
module testbench;
    import fbr_pkg::*;

    localparam int FREE_SLOTS = 65;
    localparam int LIVE_SLOTS = 64;
    localparam int RANDOM_ITEMS = 1300;
    localparam int IDLE_LIMIT = 40000;
    localparam logic [32:0] WHOLE_SPACE = 33'h1_0000_0000;

    typedef struct {
        op_t         action;
        logic [32:0] size;
        logic [31:0] addr;
        logic [15:0] rid;
        bit          drain_first;   // hold back until all results are in
    } request_t;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] base;
        logic [15:0] tag;
        logic [32:0] free_units;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    request_t request_q[$];
    answer_t  answer_q[$];
    int       sent_cnt = 0;
    int       recv_cnt = 0;
    int       fail_cnt = 0;
    int       total_items = 0;

    // Allocator mirror
    logic [31:0] fb_base[FREE_SLOTS];
    logic [32:0] fb_len[FREE_SLOTS];
    bit          fb_ok[FREE_SLOTS];
    logic [31:0] fb_age[FREE_SLOTS];
    logic [31:0] age_ctr;
    logic [31:0] lv_base[LIVE_SLOTS];
    logic [32:0] lv_len[LIVE_SLOTS];
    logic [15:0] lv_tag[LIVE_SLOTS];
    bit          lv_ok[LIVE_SLOTS];
    logic [31:0] stale_base_q[$];
    logic [32:0] stale_len_q[$];
    logic [32:0] units_free;

    best_fit_range_allocator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // alloc_size, address, resource_id
        .s_tuser  (s_tuser),   // action
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // status, base_offset, found_resource, free_space
    );

    always #5 aclk = ~aclk;

    function automatic void enter_free(logic [31:0] b, logic [32:0] len);
        for (int i = 0; i < FREE_SLOTS; i++) begin
            if (!fb_ok[i]) begin
                fb_ok[i] = 1'b1;
                fb_base[i] = b;
                fb_len[i] = len;
                fb_age[i] = age_ctr;
                age_ctr = age_ctr + 32'd1;
                return;
            end
        end
    endfunction

    // Return one block to the free table, merging with touching neighbors
    function automatic void return_block(logic [31:0] b, logic [32:0] len);
        int prv = -1;
        int nxt = -1;
        logic [32:0] b33;
        for (int i = 0; i < FREE_SLOTS; i++) begin
            if (!fb_ok[i]) continue;
            if (fb_base[i] <= b) begin
                if (prv < 0 || fb_base[i] > fb_base[prv]) prv = i;
            end else begin
                if (nxt < 0 || fb_base[i] < fb_base[nxt]) nxt = i;
            end
        end
        units_free = units_free + len;
        b33 = {1'b0, b};
        if (prv >= 0 && {1'b0, fb_base[prv]} + fb_len[prv] == b33) begin
            b33 = {1'b0, fb_base[prv]};
            len = len + fb_len[prv];
            fb_ok[prv] = 1'b0;
        end
        if (nxt >= 0 && b33 + len == {1'b0, fb_base[nxt]}) begin
            len = len + fb_len[nxt];
            fb_ok[nxt] = 1'b0;
        end
        enter_free(b33[31:0], len);
    endfunction

    function automatic int live_hit(logic [31:0] a);
        for (int i = 0; i < LIVE_SLOTS; i++)
            if (lv_ok[i] && lv_base[i] <= a && {1'b0, a - lv_base[i]} < lv_len[i])
                return i;
        return -1;
    endfunction

    // Work out the answer to one request and advance the mirror
    function automatic answer_t allocator_step(request_t r);
        answer_t ans;
        int used;
        int best = -1;
        int k;
        logic [32:0] rem;
        logic [31:0] blk_base;
        ans = '{ST_OK, 32'd0, 16'd0, 33'd0};
        case (r.action)
            OP_ALLOC: begin
                used = stale_base_q.size();
                foreach (lv_ok[i]) if (lv_ok[i]) used++;
                if (r.size == 0) ans.status = ST_BAD_SIZE;
                else if (used >= LIVE_SLOTS) ans.status = ST_FULL;
                else begin
                    for (int i = 0; i < FREE_SLOTS; i++) begin
                        if (!fb_ok[i] || fb_len[i] < r.size) continue;
                        if (best < 0 || fb_len[i] < fb_len[best] ||
                            (fb_len[i] == fb_len[best] && fb_age[i] < fb_age[best]))
                            best = i;
                    end
                    if (best < 0) ans.status = ST_NO_FIT;
                    else begin
                        // the remainder may land in the same slot
                        blk_base = fb_base[best];
                        rem = fb_len[best] - r.size;
                        fb_ok[best] = 1'b0;
                        if (rem != 0) enter_free(blk_base + r.size[31:0], rem);
                        units_free = units_free - r.size;
                        for (k = 0; k < LIVE_SLOTS; k++) begin
                            if (!lv_ok[k]) begin
                                lv_ok[k] = 1'b1;
                                lv_base[k] = blk_base;
                                lv_len[k] = r.size;
                                lv_tag[k] = r.rid;
                                break;
                            end
                        end
                        ans.base = blk_base;
                    end
                end
            end
            OP_FREE: begin
                k = live_hit(r.addr);
                if (k < 0) ans.status = ST_NOT_LIVE;
                else begin
                    stale_base_q.push_back(lv_base[k]);
                    stale_len_q.push_back(lv_len[k]);
                    lv_ok[k] = 1'b0;
                    ans.base = lv_base[k];
                    ans.tag = lv_tag[k];
                end
            end
            OP_CLEANUP: begin
                while (stale_base_q.size() > 0)
                    return_block(stale_base_q.pop_front(), stale_len_q.pop_front());
            end
            default: begin
                k = live_hit(r.addr);
                if (k < 0) ans.status = ST_NOT_LIVE;
                else begin
                    ans.base = lv_base[k];
                    ans.tag = lv_tag[k];
                end
            end
        endcase
        ans.free_units = units_free;
        return ans;
    endfunction

    function automatic void add_request(op_t act, logic [32:0] size, logic [31:0] addr,
                                        logic [15:0] rid, bit drain);
        request_t r;
        r = '{act, size, addr, rid, drain};
        request_q.push_back(r);
        answer_q.push_back(allocator_step(r));
        total_items++;
    endfunction

    // Address inside some live allocation, or random when none is live
    function automatic logic [31:0] live_address();
        int idx[$];
        int k;
        logic [63:0] off;
        foreach (lv_ok[i]) if (lv_ok[i]) idx.push_back(i);
        if (idx.size() == 0) return $urandom;
        k = idx[$urandom_range(0, idx.size() - 1)];
        off = {$urandom, $urandom} % {31'd0, lv_len[k]};
        return lv_base[k] + off[31:0];
    endfunction

    function automatic logic [32:0] random_size();
        int bits;
        logic [32:0] s;
        if ($urandom_range(0, 9) == 0) bits = $urandom_range(13, 33);
        else bits = $urandom_range(1, 12);
        s = {1'($urandom_range(0, 1)), $urandom};
        s = s >> (33 - bits);
        return (s == 0 && $urandom_range(0, 7) != 0) ? 33'd1 : s;
    endfunction

    // Stimulus: directed corners, then weighted random traffic
    initial begin
        int pick;
        op_t act;
        for (int i = 0; i < FREE_SLOTS; i++) begin
            fb_ok[i] = 1'b0;
            fb_base[i] = '0;
            fb_len[i] = '0;
            fb_age[i] = '0;
        end
        foreach (lv_ok[i]) lv_ok[i] = 1'b0;
        fb_ok[0] = 1'b1;
        fb_len[0] = WHOLE_SPACE;
        age_ctr = 32'd1;
        units_free = WHOLE_SPACE;

        add_request(OP_ALLOC, 33'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);   // zero size
        add_request(OP_ALLOC, WHOLE_SPACE, 32'd0, 16'hFFFF, 1'b0);     // whole space
        add_request(OP_ALLOC, 33'd1, 32'd0, 16'h1234, 1'b0);           // nothing fits
        add_request(OP_LOOKUP, 33'd0, 32'hFFFF_FFFF, 16'd0, 1'b0);
        add_request(OP_FREE, 33'h1_FFFF_FFFF, 32'h8000_0000, 16'd0, 1'b0);
        add_request(OP_LOOKUP, 33'd0, 32'd0, 16'd0, 1'b0);             // unknown address
        add_request(OP_FREE, 33'd0, 32'd0, 16'd0, 1'b0);               // unknown address
        add_request(OP_ALLOC, 33'd1, 32'd0, 16'd1, 1'b0);              // still stale
        add_request(OP_CLEANUP, 33'd0, 32'd0, 16'd0, 1'b0);
        add_request(OP_CLEANUP, 33'd0, 32'd0, 16'd0, 1'b0);            // empty queue
        add_request(OP_ALLOC, 33'h1_FFFF_FFFF, 32'd0, 16'd0, 1'b0);    // above space
        add_request(OP_ALLOC, 33'd1, 32'd0, 16'h0000, 1'b0);
        add_request(OP_ALLOC, 33'd16, 32'd0, 16'hA5A5, 1'b0);
        add_request(OP_ALLOC, 33'd16, 32'd0, 16'h5A5A, 1'b0);
        add_request(OP_ALLOC, 33'hFFFF_FF00, 32'd0, 16'h00FF, 1'b0);
        add_request(OP_FREE, 33'd0, 32'd0, 16'd0, 1'b0);
        add_request(OP_FREE, 33'd0, 32'd20, 16'd0, 1'b0);
        add_request(OP_LOOKUP, 33'd0, 32'd5, 16'd0, 1'b0);
        add_request(OP_CLEANUP, 33'd0, 32'd0, 16'd0, 1'b0);           // no merge: a live block lies between
        add_request(OP_ALLOC, 33'd8, 32'd0, 16'h0F0F, 1'b0);            // best fit: smallest block that fits
        add_request(OP_FREE, 33'd0, 32'd1, 16'd0, 1'b0);
        add_request(OP_CLEANUP, 33'd0, 32'd0, 16'd0, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) act = OP_ALLOC;
            else if (pick < 70) act = OP_FREE;
            else if (pick < 94) act = OP_LOOKUP;
            else act = OP_CLEANUP;
            add_request(act, random_size(),
                        ($urandom_range(0, 9) < 7) ? live_address() : $urandom,
                        16'($urandom), n == RANDOM_ITEMS / 2);
        end

        do @(posedge aclk);
        while (!(sent_cnt == total_items && answer_q.size() == 0));
        repeat (200) @(posedge aclk);
        if (fail_cnt == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    // Reset
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: random gaps, one drain pause
    int src_gap = 0;
    always @(posedge aclk) begin
        int sent_now;
        int roll;
        request_t r;
        sent_now = sent_cnt;
        if (aresetn) begin
            if (s_tvalid && s_tready) sent_now++;
            sent_cnt <= sent_now;
            if (!(s_tvalid && !s_tready)) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (request_q.size() > 0 &&
                             !(request_q[0].drain_first && recv_cnt != sent_now)) begin
                    r = request_q.pop_front();
                    s_tdata <= {7'd0, r.rid, r.addr, r.size};
                    s_tuser <= r.action;
                    s_tvalid <= 1'b1;
                    roll = $urandom_range(0, 99);
                    if (roll < 60) src_gap <= 0;
                    else if (roll < 95) src_gap <= $urandom_range(1, 4);
                    else src_gap <= $urandom_range(10, 80);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer, with random and one long back-pressure
    int sink_hold = 0;
    bit long_hold_done = 0;
    always @(posedge aclk) begin
        answer_t exp_ans;
        int roll;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                recv_cnt <= recv_cnt + 1;
                if (answer_q.size() == 0) begin
                    $error("unexpected result transfer");
                    fail_cnt++;
                end else begin
                    exp_ans = answer_q.pop_front();
                    if (m_tdata[2:0] !== exp_ans.status) begin
                        $error("status: expected %0d, got %0d", exp_ans.status, m_tdata[2:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[34:3] !== exp_ans.base) begin
                        $error("base_offset: expected %h, got %h", exp_ans.base,
                               m_tdata[34:3]);
                        fail_cnt++;
                    end
                    if (m_tdata[50:35] !== exp_ans.tag) begin
                        $error("found_resource: expected %h, got %h", exp_ans.tag,
                               m_tdata[50:35]);
                        fail_cnt++;
                    end
                    if (m_tdata[83:51] !== exp_ans.free_units) begin
                        $error("free_space: expected %h, got %h", exp_ans.free_units,
                               m_tdata[83:51]);
                        fail_cnt++;
                    end
                end
            end
            if (!long_hold_done && recv_cnt == 300) begin
                long_hold_done <= 1'b1;
                sink_hold <= 3000;
                m_tready <= 1'b0;
            end else if (sink_hold > 0) begin
                sink_hold <= sink_hold - 1;
                m_tready <= 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 65) m_tready <= 1'b1;
                else if (roll < 96) begin
                    m_tready <= 1'b0;
                    sink_hold <= $urandom_range(0, 3);
                end else begin
                    m_tready <= 1'b0;
                    sink_hold <= $urandom_range(20, 150);
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else idle_cycles <= idle_cycles + 1;
    end

endmodule

>>> files.f
rtl/fbr_pkg.sv
rtl/fbr_free_cell.sv
rtl/fbr_live_cell.sv
rtl/best_fit_range_allocator.sv
bench/testbench.sv
